[src/ogcf_pkg.sv]
`timescale 1ns / 1ps
package ogcf_pkg;

  localparam int W       = 28;
  localparam int ZW      = 21;
  localparam int STEPS   = 16;
  localparam int IW      = 4;
  localparam int QDEPTH  = 2;
  localparam int BW      = 16;

  localparam logic signed [ZW-1:0] HALF_PI = ZW'(102944);
  localparam logic signed [ZW-1:0] FULL_PI = ZW'(205888);
  localparam logic signed [ZW-1:0] TWO_PI  = ZW'(411776);
  localparam logic [15:0] KINV = 16'd39797;

  localparam logic CFG_OFFSET    = 1'b0;
  localparam logic CFG_CLEARANCE = 1'b1;

  typedef struct packed {
    logic [11:0]        range_mm;
    logic signed [17:0] zang;
    logic               last;
  } item_t;

  function automatic logic signed [ZW-1:0] atan_tab(input logic [IW-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      4'd0:    v = ZW'(51472);
      4'd1:    v = ZW'(30385);
      4'd2:    v = ZW'(16055);
      4'd3:    v = ZW'(8150);
      4'd4:    v = ZW'(4091);
      4'd5:    v = ZW'(2047);
      4'd6:    v = ZW'(1024);
      4'd7:    v = ZW'(512);
      4'd8:    v = ZW'(256);
      4'd9:    v = ZW'(128);
      4'd10:   v = ZW'(64);
      4'd11:   v = ZW'(32);
      4'd12:   v = ZW'(16);
      4'd13:   v = ZW'(8);
      4'd14:   v = ZW'(4);
      default: v = ZW'(2);
    endcase
    return v;
  endfunction

  function automatic logic signed [ZW-1:0] wrap_angle(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] r;
    r = z;
    if (r > FULL_PI) r = r - TWO_PI;
    if (r < -FULL_PI) r = r + TWO_PI;
    return r;
  endfunction

endpackage

[src/ogcf_front.sv]
`timescale 1ns / 1ps
module ogcf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [11:0]        range_mm,
  input  logic signed [14:0] bearing,
  input  logic               last,
  output logic               q_valid,
  output ogcf_pkg::item_t    q_item,
  input  logic               q_pop
);

  ogcf_pkg::item_t mem_r [ogcf_pkg::QDEPTH];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr, rd;
  ogcf_pkg::item_t it;

  assign full    = (cnt_r == 2'(ogcf_pkg::QDEPTH));
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];
  assign wr = push & ~full;
  assign rd = q_pop & q_valid;

  always_comb begin
    it.range_mm = range_mm;
    it.zang     = {{3{bearing[14]}}, bearing} <<< 3;
    it.last     = last;
    wp_nxt  = wp_r ^ wr;
    rp_nxt  = rp_r ^ rd;
    cnt_nxt = cnt_r + 2'(wr) - 2'(rd);
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= it;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[src/ogcf_cordic.sv]
`timescale 1ns / 1ps
module ogcf_cordic (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             vec,
  input  logic signed [ogcf_pkg::W-1:0]    x0,
  input  logic signed [ogcf_pkg::W-1:0]    y0,
  input  logic signed [ogcf_pkg::ZW-1:0]   z0,
  output logic                             done,
  output logic signed [ogcf_pkg::W-1:0]    x_o,
  output logic signed [ogcf_pkg::W-1:0]    y_o,
  output logic signed [ogcf_pkg::ZW-1:0]   z_o
);

  typedef enum logic [3:0] {
    C_IDLE  = 4'b0001,
    C_SCALE = 4'b0010,
    C_ITER  = 4'b0100,
    C_MAG   = 4'b1000
  } cst_t;

  cst_t state_r, state_nxt;
  logic vec_r, vec_nxt, done_r, done_nxt;
  logic [ogcf_pkg::IW-1:0] i_r, i_nxt;
  logic signed [ogcf_pkg::W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [ogcf_pkg::ZW-1:0] z_r, z_nxt;
  logic signed [ogcf_pkg::W-1:0] xs, ys;
  logic signed [ogcf_pkg::ZW-1:0] at;
  logic dir;

  function automatic logic signed [ogcf_pkg::W-1:0] unscale(
      input logic signed [ogcf_pkg::W-1:0] v);
    logic signed [ogcf_pkg::W+16:0] p;
    p = v * $signed({1'b0, ogcf_pkg::KINV});
    p = p + (ogcf_pkg::W+17)'(32768);
    p = p >>> 16;
    return p[ogcf_pkg::W-1:0];
  endfunction

  assign done = done_r;
  assign x_o  = x_r;
  assign y_o  = y_r;
  assign z_o  = z_r;

  always_comb begin
    state_nxt = state_r;
    vec_nxt   = vec_r;
    i_nxt     = i_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    done_nxt  = 1'b0;
    xs  = x_r >>> i_r;
    ys  = y_r >>> i_r;
    at  = ogcf_pkg::atan_tab(i_r);
    dir = vec_r ? (y_r >= 0) : (z_r >= 0);
    unique case (state_r)
      C_IDLE: begin
        if (start) begin
          vec_nxt = vec;
          i_nxt   = '0;
          x_nxt = x0;
          y_nxt = y0;
          z_nxt = z0;
          if (vec) begin
            if (x0 == 0 && y0 == 0) begin
              done_nxt = 1'b1;
            end else begin
              z_nxt = '0;
              if (x0 < 0) begin
                if (y0 >= 0) begin
                  x_nxt = y0;  y_nxt = -x0; z_nxt = ogcf_pkg::HALF_PI;
                end else begin
                  x_nxt = -y0; y_nxt = x0;  z_nxt = -ogcf_pkg::HALF_PI;
                end
              end
              state_nxt = C_ITER;
            end
          end else begin
            if (z0 > ogcf_pkg::HALF_PI) begin
              x_nxt = -y0; y_nxt = x0; z_nxt = z0 - ogcf_pkg::HALF_PI;
            end else if (z0 < -ogcf_pkg::HALF_PI) begin
              x_nxt = y0; y_nxt = -x0; z_nxt = z0 + ogcf_pkg::HALF_PI;
            end
            state_nxt = C_SCALE;
          end
        end
      end
      C_SCALE: begin
        x_nxt = unscale(x_r);
        y_nxt = unscale(y_r);
        state_nxt = C_ITER;
      end
      C_ITER: begin
        if (vec_r ? dir : dir) begin
          x_nxt = vec_r ? x_r + ys : x_r - ys;
          y_nxt = vec_r ? y_r - xs : y_r + xs;
          z_nxt = vec_r ? z_r + at : z_r - at;
        end else begin
          x_nxt = vec_r ? x_r - ys : x_r + ys;
          y_nxt = vec_r ? y_r + xs : y_r - xs;
          z_nxt = vec_r ? z_r - at : z_r + at;
        end
        i_nxt = i_r + 1'b1;
        if (i_r == ogcf_pkg::IW'(ogcf_pkg::STEPS - 1)) begin
          if (vec_r) begin
            state_nxt = C_MAG;
          end else begin
            state_nxt = C_IDLE;
            done_nxt  = 1'b1;
          end
        end
      end
      C_MAG: begin
        x_nxt = unscale(x_r);
        state_nxt = C_IDLE;
        done_nxt  = 1'b1;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    i_r <= i_nxt;
    vec_r <= vec_nxt;
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

[src/ogcf_back.sv]
`timescale 1ns / 1ps
module ogcf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [9:0]          offset_mm,
  input  logic [11:0]         clearance_mm,
  input  logic                q_valid,
  input  ogcf_pkg::item_t     q_item,
  output logic                q_pop,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [14:0]  out_best_bearing,
  output logic                out_found
);

  localparam int W  = ogcf_pkg::W;
  localparam int ZW = ogcf_pkg::ZW;

  typedef enum logic [6:0] {
    B_IDLE = 7'b0000001,
    B_ROT1 = 7'b0000010,
    B_VEC1 = 7'b0000100,
    B_VEC2 = 7'b0001000,
    B_ROT2 = 7'b0010000,
    B_ROT3 = 7'b0100000,
    B_UPD  = 7'b1000000
  } bst_t;

  bst_t state_r, state_nxt;
  logic c_start, c_vec, c_done;
  logic signed [W-1:0]  c_x0, c_y0, c_x, c_y;
  logic signed [ZW-1:0] c_z0, c_z;

  logic signed [W-1:0]  x_r, x_nxt, y_r, y_nxt, d_r, d_nxt;
  logic signed [ZW-1:0] a_r, a_nxt, th_r, th_nxt;
  logic signed [W-1:0]  px_r, px_nxt, py_r, py_nxt, pd_r, pd_nxt;
  logic signed [ZW-1:0] pa_r, pa_nxt;
  logic have_r, have_nxt, any_r, any_nxt, last_r, last_nxt, ok_r, ok_nxt;
  logic signed [ogcf_pkg::BW-1:0] best_r, best_nxt, qv;
  logic ov_r, ov_nxt;
  logic signed [14:0] ob_r, ob_nxt;
  logic of_r, of_nxt;
  logic signed [W-1:0]  xs;
  logic signed [ZW-1:0] th;
  logic signed [ZW-1:0] th4;
  logic clr;

  function automatic logic beyond(input logic signed [W-1:0] v, input logic [11:0] c);
    logic signed [W-1:0] m;
    m = (v < 0) ? -v : v;
    return m > $signed({{(W-20){1'b0}}, c, 8'b0});
  endfunction

  ogcf_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(c_start), .vec(c_vec),
    .x0(c_x0), .y0(c_y0), .z0(c_z0), .done(c_done),
    .x_o(c_x), .y_o(c_y), .z_o(c_z)
  );

  assign out_empty        = ~ov_r;
  assign out_best_bearing = ob_r;
  assign out_found        = of_r;

  always_comb begin
    state_nxt = state_r;
    c_start = 1'b0; c_vec = 1'b0;
    c_x0 = '0; c_y0 = '0; c_z0 = '0;
    q_pop = 1'b0;
    x_nxt = x_r; y_nxt = y_r; d_nxt = d_r; a_nxt = a_r; th_nxt = th_r;
    px_nxt = px_r; py_nxt = py_r; pd_nxt = pd_r; pa_nxt = pa_r;
    have_nxt = have_r; any_nxt = any_r; last_nxt = last_r; ok_nxt = ok_r;
    best_nxt = best_r;
    ob_nxt = ob_r; of_nxt = of_r;
    ov_nxt = ov_r & ~out_pop;
    xs = c_x + $signed({{(W-18){1'b0}}, offset_mm, 8'b0});
    th = c_z;
    if (c_z > ogcf_pkg::HALF_PI) th = c_z - ogcf_pkg::FULL_PI;
    else if (c_z < -ogcf_pkg::HALF_PI) th = c_z + ogcf_pkg::FULL_PI;
    th4 = (th_r + ZW'(4)) >>> 3;
    qv = th4[ogcf_pkg::BW-1:0];
    clr = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (q_valid && !(q_item.last && ov_r)) begin
          q_pop = 1'b1;
          last_nxt = q_item.last;
          c_start = 1'b1;
          c_x0 = $signed({{(W-20){1'b0}}, q_item.range_mm, 8'b0});
          c_z0 = ZW'(q_item.zang);
          state_nxt = B_ROT1;
        end
      end
      B_ROT1: begin
        if (c_done) begin
          x_nxt = xs; y_nxt = c_y;
          c_start = 1'b1; c_vec = 1'b1; c_x0 = xs; c_y0 = c_y;
          state_nxt = B_VEC1;
        end
      end
      B_VEC1: begin
        if (c_done) begin
          d_nxt = c_x; a_nxt = c_z;
          if (have_r) begin
            c_start = 1'b1; c_vec = 1'b1;
            c_x0 = px_r + x_r; c_y0 = py_r + y_r;
            state_nxt = B_VEC2;
          end else begin
            state_nxt = B_UPD;
          end
        end
      end
      B_VEC2: begin
        if (c_done) begin
          th_nxt = th;
          c_start = 1'b1; c_x0 = pd_r;
          c_z0 = ogcf_pkg::wrap_angle(th - pa_r);
          state_nxt = B_ROT2;
        end
      end
      B_ROT2: begin
        if (c_done) begin
          ok_nxt = beyond(c_y, clearance_mm);
          c_start = 1'b1; c_x0 = d_r;
          c_z0 = ogcf_pkg::wrap_angle(th_r - a_r);
          state_nxt = B_ROT3;
        end
      end
      B_ROT3: begin
        if (c_done) begin
          if (ok_r && beyond(c_y, clearance_mm)) begin
            if (!any_r || qv < best_r) best_nxt = qv;
            any_nxt = 1'b1;
          end
          state_nxt = B_UPD;
        end
      end
      B_UPD: begin
        px_nxt = x_r; py_nxt = y_r; pd_nxt = d_r; pa_nxt = a_r;
        have_nxt = 1'b1;
        if (last_r) begin
          ob_nxt = any_r ? best_r[14:0] : 15'sd0;
          of_nxt = any_r;
          ov_nxt = 1'b1;
          clr = 1'b1;
        end
        state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
    if (clr) begin
      have_nxt = 1'b0; any_nxt = 1'b0; best_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; d_r <= d_nxt; a_r <= a_nxt; th_r <= th_nxt;
    last_r <= last_nxt; ok_r <= ok_nxt;
    ob_r <= ob_nxt; of_r <= of_nxt;
    if (!rst_n) begin
      state_r <= B_IDLE;
      px_r <= '0; py_r <= '0; pd_r <= '0; pa_r <= '0;
      have_r <= 1'b0; any_r <= 1'b0; best_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      px_r <= px_nxt; py_r <= py_nxt; pd_r <= pd_nxt; pa_r <= pa_nxt;
      have_r <= have_nxt; any_r <= any_nxt; best_r <= best_nxt;
      ov_r <= ov_nxt;
    end
  end

endmodule

[src/obstacle_gap_corridor_finder_core.sv]
`timescale 1ns / 1ps
// Corridor finder for one range-sensor sweep. Push readings (range, Q2.13
// bearing, last); a word with last set yields one result word (smallest
// accepted corridor bearing, found flag). All trig runs on one shared
// 16-step CORDIC. The first reading of a sweep takes two passes plus
// two control states; later readings take five passes plus two. A zero
// vector in vectoring mode skips the iterations. A reading with last set
// waits while an earlier result word is still unread. A two-word input
// queue decouples the pusher from the engine.
module obstacle_gap_corridor_finder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [11:0]        cfg_wdata,
  input  logic               in_push,
  output logic               in_full,
  input  logic [11:0]        in_range_mm,
  input  logic signed [14:0] in_bearing,
  input  logic               in_last,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [14:0] out_best_bearing,
  output logic               out_found
);

  logic [9:0]  offset_r;
  logic [11:0] clear_r;
  logic q_valid, q_pop;
  ogcf_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= 10'd240;
      clear_r  <= 12'd333;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        ogcf_pkg::CFG_OFFSET:    offset_r <= cfg_wdata[9:0];
        ogcf_pkg::CFG_CLEARANCE: clear_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ogcf_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .full(in_full),
    .range_mm(in_range_mm), .bearing(in_bearing), .last(in_last),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  ogcf_back u_back (
    .clk(clk), .rst_n(rst_n), .offset_mm(offset_r), .clearance_mm(clear_r),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_best_bearing(out_best_bearing), .out_found(out_found)
  );

endmodule
